>>> design/stis_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table interpolation search package
// Shared request/response types, op and status codes, controller states.
// ----------------------------------------------------------------------------
package stis_pkg;

   localparam int unsigned ValueWidth    = 32;
   localparam int unsigned PositionWidth = 6;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2,
      ST_RSVD = 2'd3
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic signed [31:0]       value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [5:0]               position;
   } rsp_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,     // read entry pos-1
      S_INS_CMP,    // compare / shift one entry up
      S_INS_WR,     // write value at pos
      S_SR_RDLO,    // read v[lo]
      S_SR_RDHI,    // read v[hi]
      S_SR_CHK,     // range test, start divide
      S_SR_DIV,     // serial divide
      S_SR_RDMID,   // read v[mid]
      S_SR_CMP,     // compare probe
      S_RESP        // hold response
   } state_type;

   // datapath commands
   typedef struct packed {
      logic load_req;     // capture request, init pointers
      logic clear;        // empty table
      logic rd_prev;      // read address pos-1
      logic shift_up;     // write rd data at pos, pos--
      logic wr_val;       // write value at pos, count++
      logic rd_lo;
      logic rd_hi;
      logic rd_mid;
      logic div_start;
      logic div_step;
      logic go_lo;        // lo = mid+1
      logic go_hi;        // hi = mid-1
      logic set_found;
      logic set_full;
      logic rsp_load;
   } cmd_type;

   // datapath status
   typedef struct packed {
      logic full;
      logic pos_zero;     // insert pointer at 0
      logic prev_gt;      // read data > value
      logic in_range;     // lo<=hi and key within ends
      logic div_done;
      logic mid_eq;
      logic mid_lt;
      logic rsp_taken;
   } sts_type;

endpackage

>>> design/stis_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted table interpolation search controller
// Sequences insert shifts and search probes through the datapath.
// ----------------------------------------------------------------------------
module stis_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  stis_pkg::op_type req_op,
   input  stis_pkg::sts_type sts,
   output logic             req_stall,
   output logic             rsp_valid,
   output stis_pkg::cmd_type cmd
);
   import stis_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_APPEND: state_in = sts.full ? S_RESP : S_INS_RD;
                  OP_SEARCH: state_in = S_SR_RDLO;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_INS_RD:   state_in = sts.pos_zero ? S_INS_WR : S_INS_CMP;
         S_INS_CMP:  state_in = sts.prev_gt ? S_INS_RD : S_INS_WR;
         S_INS_WR:   state_in = S_RESP;
         S_SR_RDLO:  state_in = S_SR_RDHI;
         S_SR_RDHI:  state_in = S_SR_CHK;
         S_SR_CHK:   state_in = sts.in_range ? S_SR_DIV : S_RESP;
         S_SR_DIV:   state_in = sts.div_done ? S_SR_RDMID : S_SR_DIV;
         S_SR_RDMID: state_in = S_SR_CMP;
         S_SR_CMP:   state_in = sts.mid_eq ? S_RESP : S_SR_RDLO;
         S_RESP:     state_in = sts.rsp_taken ? S_IDLE : S_RESP;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_op)
                  OP_CLEAR:  begin cmd.clear = 1'b1; cmd.rsp_load = 1'b1; end
                  OP_APPEND: begin
                     if (sts.full) begin
                        cmd.set_full = 1'b1;
                        cmd.rsp_load = 1'b1;
                     end
                  end
                  OP_SEARCH: ;
                  default:   cmd.rsp_load = 1'b1;
               endcase
            end
         end
         S_INS_RD:   if (!sts.pos_zero) cmd.rd_prev = 1'b1;
         S_INS_CMP:  if (sts.prev_gt) cmd.shift_up = 1'b1;
         S_INS_WR:   begin cmd.wr_val = 1'b1; cmd.rsp_load = 1'b1; end
         S_SR_RDLO:  cmd.rd_lo = 1'b1;
         S_SR_RDHI:  cmd.rd_hi = 1'b1;
         S_SR_CHK:   begin
            if (sts.in_range) cmd.div_start = 1'b1;
            else cmd.rsp_load = 1'b1;
         end
         S_SR_DIV:   cmd.div_step = 1'b1;
         S_SR_RDMID: cmd.rd_mid = 1'b1;
         S_SR_CMP:   begin
            if (sts.mid_eq) begin
               cmd.set_found = 1'b1;
               cmd.rsp_load  = 1'b1;
            end else if (sts.mid_lt) cmd.go_lo = 1'b1;
            else cmd.go_hi = 1'b1;
         end
         S_RESP:     ;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> design/stis_dp.sv
// ----------------------------------------------------------------------------
// Sorted table interpolation search datapath
// Table memory, count, pointers, serial divider and response register.
// ----------------------------------------------------------------------------
module stis_dp #(
   parameter int unsigned DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  stis_pkg::req_type req_data,
   input  stis_pkg::cmd_type cmd,
   input  logic              rsp_stall,
   input  logic              rsp_valid,
   output stis_pkg::sts_type sts,
   output stis_pkg::rsp_type rsp_data
);
   import stis_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   // quotient bits: (hi-lo)*(key-vlo)/span < DEPTH
   localparam int unsigned NW = AW + 33;   // numerator width
   localparam int unsigned QW = AW;
   localparam int unsigned NSTEPS = NW;
   localparam int unsigned SW = $clog2(NSTEPS + 1);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_ff;
   logic signed [31:0] key_ff;
   logic signed [31:0] vlo_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] pos_ff;                  // insert pointer
   logic signed [AW+1:0] lo_ff, hi_ff;     // signed so hi can drop below lo
   logic [AW-1:0] mid_ff;
   rsp_type rsp_ff;

   // divider state
   logic [NW-1:0] num_ff;
   logic [32:0]   den_ff;
   logic [32:0]   rem_ff;
   logic [SW-1:0] step_ff;
   logic [AW-1:0] base_ff;

   // memory read address
   logic [AW-1:0] rd_addr;
   always_comb begin
      rd_addr = lo_ff[AW-1:0];
      if (cmd.rd_prev)     rd_addr = AW'(pos_ff - CW'(1));
      else if (cmd.rd_hi)  rd_addr = hi_ff[AW-1:0];
      else if (cmd.rd_mid) rd_addr = mid_ff;
   end

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.shift_up) mem[pos_ff[AW-1:0]] <= rd_ff;
      else if (cmd.wr_val) mem[pos_ff[AW-1:0]] <= key_ff;
      rd_ff <= mem[rd_addr];
   end

   // low end value latches in the cycle after its read
   logic rd_lo_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_lo_d_ff <= 1'b0;
      end else begin
         rd_lo_d_ff <= cmd.rd_lo;
      end
   end
   always_ff @(posedge clock) begin
      if (rd_lo_d_ff) vlo_ff <= rd_ff;
   end

   // count and pointers
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.clear) count_ff <= '0;
      else if (cmd.wr_val) count_ff <= count_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff <= req_data.value;
         pos_ff <= count_ff;
         lo_ff  <= '0;
         hi_ff  <= (AW+2)'(count_ff) - (AW+2)'(1);
      end else begin
         if (cmd.shift_up) pos_ff <= pos_ff - CW'(1);
         if (cmd.go_lo) lo_ff <= (AW+2)'(mid_ff) + (AW+2)'(1);
         if (cmd.go_hi) hi_ff <= (AW+2)'(mid_ff) - (AW+2)'(1);
      end
   end

   // range test: the high end value is still on the read port here
   logic signed [32:0] span_s;
   logic [AW:0]        width_u;
   logic [32:0]        kdiff;
   assign span_s  = 33'(rd_ff) - 33'(vlo_ff);
   assign width_u = (AW+1)'(hi_ff - lo_ff);
   assign kdiff   = 33'(key_ff) - 33'(vlo_ff);

   // numerator product: width (<= AW bits) times kdiff (33 bits)
   logic [NW-1:0] prod;
   assign prod = NW'(width_u[AW-1:0]) * NW'(kdiff);

   // restoring divider, one quotient bit per cycle
   logic [33:0] rem_sh;
   logic [33:0] rem_sub;
   assign rem_sh  = {rem_ff, num_ff[NW-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         base_ff <= lo_ff[AW-1:0];
         den_ff  <= span_s;
         rem_ff  <= '0;
         num_ff  <= (span_s == '0) ? '0 : prod;
         step_ff <= (span_s == '0) ? SW'(NSTEPS) : '0;
      end else if (cmd.div_step) begin
         if (step_ff != SW'(NSTEPS)) begin
            step_ff <= step_ff + SW'(1);
            if (!rem_sub[33]) begin
               rem_ff <= rem_sub[32:0];
               num_ff <= {num_ff[NW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[32:0];
               num_ff <= {num_ff[NW-2:0], 1'b0};
            end
         end else begin
            mid_ff <= base_ff + num_ff[QW-1:0];
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rsp_ff.status   <= ST_MISS;
         rsp_ff.position <= '0;
      end
      if (cmd.rsp_load) begin
         if (cmd.set_found) begin
            rsp_ff.status   <= ST_OK;
            rsp_ff.position <= 6'(mid_ff);
         end else if (cmd.set_full) begin
            rsp_ff.status   <= ST_FULL;
            rsp_ff.position <= '0;
         end else if (cmd.wr_val || cmd.load_req) begin
            rsp_ff.status   <= ST_OK;
            rsp_ff.position <= '0;
         end
      end
   end

   // status to controller
   always_comb begin
      sts.full      = (count_ff >= CW'(DEPTH));
      sts.pos_zero  = (pos_ff == '0);
      sts.prev_gt   = (rd_ff > key_ff);
      sts.in_range  = (lo_ff <= hi_ff) && (key_ff >= vlo_ff) && (key_ff <= rd_ff);
      sts.div_done  = cmd.div_step && (step_ff == SW'(NSTEPS));
      sts.mid_eq    = (rd_ff == key_ff);
      sts.mid_lt    = (rd_ff < key_ff);
      sts.rsp_taken = rsp_valid && !rsp_stall;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> design/sorted_table_interpolation_search_core.sv
// Clear empties the table. Append shifts each entry greater than the value up one place, then
// writes the value below them; an append on a full table returns a full status. Search reads
// both ends and runs one probe after another, each through the serial divider (one quotient
// bit a cycle over a (log2 DEPTH + 33)-bit numerator), ending on a hit or when out of range.
// One request at a time; the next is taken after the response is accepted.
// Reset (synchronous, high) empties the table; table contents are undefined.
// ----------------------------------------------------------------------------
// Sorted table interpolation search core
// Sorted signed table with append, clear and interpolation search.
// ----------------------------------------------------------------------------
module sorted_table_interpolation_search_core #(
   parameter int unsigned DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stis_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stis_pkg::rsp_type rsp_data
);
   import stis_pkg::*;

   cmd_type cmd;
   sts_type sts;

   stis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .sts       (sts),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   stis_dp #(.DEPTH(DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/stis_checker.sv
// ----------------------------------------------------------------------------
// Sorted table interpolation search port checker
// Watches the top level ports for handshake and ordering slips.
// ----------------------------------------------------------------------------
module stis_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input stis_pkg::rsp_type rsp_data
);
   import stis_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // no request is taken while a response is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted with response pending");

   // position is zero unless found
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.position == '0)
      else $error("nonzero position on miss or full");

   // status code 3 never appears
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != ST_RSVD)
      else $error("reserved status");

endmodule

bind sorted_table_interpolation_search_core stis_checker u_stis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
